// ===== design/sit_pkg.sv =====
// shared types and constants of the sorted insert table
`default_nettype none

package sit_pkg;

    localparam int unsigned DEPTH   = 16;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned IDX_W   = 4;
    localparam int unsigned CNT_W   = 5;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_READ   = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STS_OK     = 2'd0,
        STS_FULL   = 2'd1,
        STS_BADIDX = 2'd2,
        STS_DUP    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]                op;
        logic signed [VALUE_W-1:0] value;
        logic [IDX_W-1:0]          index;
    } t_in_word;

    typedef struct packed {
        logic signed [VALUE_W-1:0] read_value;
        logic [CNT_W-1:0]          entry_count;
        logic [1:0]                status;
    } t_out_word;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [IDX_W-1:0]          index;
        logic [CNT_W-1:0]          count;
        logic                      do_ins;
        logic                      do_rem;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== design/sit_cell.sv =====
// one cell of the sorted chain: holds a single entry and shifts with its neighbors
`default_nettype none

module sit_cell
    import sit_pkg::*;
#(
    parameter int unsigned K = 0
) (
    input  wire logic                      i_clk,
    input  wire t_cell_ctl                 i_ctl,
    input  wire logic signed [VALUE_W-1:0] i_prev_entry,
    input  wire logic                      i_prev_ge,
    input  wire logic signed [VALUE_W-1:0] i_next_entry,
    output logic signed [VALUE_W-1:0]      o_entry,
    output logic                           o_ge,
    output logic                           o_hit
);

    localparam logic [CNT_W-1:0] POS = CNT_W'(K);

    logic signed [VALUE_W-1:0] r_entry;
    logic signed [VALUE_W-1:0] n_entry;
    logic                      used;
    logic                      first;

    // empty cells count as not smaller so the first flag marks the slot
    assign used    = (POS < i_ctl.count);
    assign o_ge    = used ? (r_entry >= i_ctl.value) : 1'b1;
    assign first   = o_ge && !i_prev_ge;
    assign o_hit   = first && used && (r_entry == i_ctl.value);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.do_ins) begin
            if (i_prev_ge) begin
                n_entry = i_prev_entry;
            end else if (first) begin
                n_entry = i_ctl.value;
            end
        end else if (i_ctl.do_rem) begin
            if (POS >= {1'b0, i_ctl.index}) begin
                n_entry = i_next_entry;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire

// ===== design/sorted_insert_table.sv =====
// top level of the sorted insert table: command register, cell chain, result register
// an accepted word is held in the command register, runs through the cell chain while
// executing, and its result waits in the result register until the receiver takes it
// no new word is taken while one executes; the next one can enter as the result leaves
// the flow is set by the command register feeding the cell chain and the single result register
// every cell compares, shifts and writes in the same cycle, so any op finishes in one chain step
// reset (synchronous, active low) empties the table and clears unique mode; entries keep no reset
`default_nettype none

module sorted_insert_table
    import sit_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_word  i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_word      o_out_word,
    input  wire logic      i_cfg_we,
    input  wire logic      i_cfg_wdata
);

    t_state    r_state;
    t_state    n_state;
    t_in_word  r_cmd;
    t_out_word r_out;
    t_out_word n_out;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic      r_unique;

    // cell chain wiring
    logic signed [VALUE_W-1:0] w_entry [DEPTH];
    logic                      w_ge    [DEPTH];
    logic [DEPTH-1:0]          w_hit;
    t_cell_ctl                 ctl;

    logic in_take;
    logic dup;
    logic full;
    logic idx_ok;
    logic exec;

    assign exec   = (r_state == ST_EXEC);
    assign dup    = r_unique && (|w_hit);
    assign full   = (r_count == CNT_W'(DEPTH));
    assign idx_ok = ({1'b0, r_cmd.index} < r_count);

    // broadcast only while executing so the chain is frozen otherwise
    always_comb begin
        ctl.value  = r_cmd.value;
        ctl.index  = r_cmd.index;
        ctl.count  = r_count;
        ctl.do_ins = exec && (r_cmd.op == OP_INSERT) && !dup && !full;
        ctl.do_rem = exec && (r_cmd.op == OP_REMOVE) && idx_ok;
    end

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic signed [VALUE_W-1:0] prev_entry;
        logic                      prev_ge;
        logic signed [VALUE_W-1:0] next_entry;

        if (k == 0) begin : g_head
            assign prev_entry = r_cmd.value;
            assign prev_ge    = 1'b0;
        end else begin : g_body
            assign prev_entry = w_entry[k-1];
            assign prev_ge    = w_ge[k-1];
        end

        if (k == DEPTH - 1) begin : g_tail
            assign next_entry = w_entry[k];
        end else begin : g_mid
            assign next_entry = w_entry[k+1];
        end

        sit_cell #(
            .K(k)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_prev_entry (prev_entry),
            .i_prev_ge    (prev_ge),
            .i_next_entry (next_entry),
            .o_entry      (w_entry[k]),
            .o_ge         (w_ge[k]),
            .o_hit        (w_hit[k])
        );
    end

    // handshake: a new word is taken when idle or when the pending result leaves
    always_comb begin
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: o_in_stall = 1'b0;
            ST_DONE: o_in_stall = i_out_stall;
            default: o_in_stall = 1'b1;
        endcase
    end

    assign in_take     = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_state == ST_DONE);
    assign o_out_word  = r_out;

    // next state, result word and count
    always_comb begin
        n_state = r_state;
        n_out   = r_out;
        n_count = r_count;
        case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state          = ST_DONE;
                n_out.read_value = '0;
                n_out.status     = STS_OK;
                case (r_cmd.op)
                    OP_INSERT: begin
                        if (dup) begin
                            n_out.status = STS_DUP;
                        end else if (full) begin
                            n_out.status = STS_FULL;
                        end else begin
                            n_count = r_count + CNT_W'(1);
                        end
                    end
                    OP_READ: begin
                        if (idx_ok) begin
                            n_out.read_value = w_entry[r_cmd.index];
                        end else begin
                            n_out.status = STS_BADIDX;
                        end
                    end
                    OP_REMOVE: begin
                        if (idx_ok) begin
                            n_count = r_count - CNT_W'(1);
                        end else begin
                            n_out.status = STS_BADIDX;
                        end
                    end
                    default: begin
                        // unused op code leaves the table alone
                    end
                endcase
                n_out.entry_count = n_count;
            end
            ST_DONE: begin
                if (!i_out_stall) begin
                    n_state = in_take ? ST_EXEC : ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_unique <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_we) begin
                r_unique <= i_cfg_wdata;
            end
        end
    end

    // payload registers carry no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cmd <= i_in_word;
        end
        r_out <= n_out;
    end

`ifndef SYNTHESIS
    // the table never holds more than its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    // a committed insert grows the count by exactly one
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.do_ins |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow count");

    // a committed remove shrinks the count by exactly one
    a_remove_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.do_rem |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("remove did not shrink count");

    // a bad index result never carries data
    a_badidx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (r_out.status == STS_BADIDX)) |-> (r_out.read_value == '0))
        else $error("bad index result carries data");

    // the reported count is the table count while the result waits
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_out.entry_count == r_count))
        else $error("result count differs from table count");
`endif

endmodule

`default_nettype wire

// ===== dv/sorted_insert_table_tb.sv =====
// self-checking testbench for the sorted insert table
`timescale 1ns / 100ps

module sorted_insert_table_tb;
    import sit_pkg::*;

    // shadow copy of the table: predicts each result and checks what comes back
    class sorted_table_shadow;
        logic signed [VALUE_W-1:0] vals [DEPTH];
        int                        count;
        bit                        unique_on;
        t_out_word                 pending [$];
        int unsigned               mismatches;

        function new();
            count      = 0;
            unique_on  = 1'b0;
            mismatches = 0;
        endfunction

        // work out the result of one accepted word and queue it
        function void note_word(t_in_word w);
            t_out_word                 r;
            t_status                   st;
            logic signed [VALUE_W-1:0] v;
            logic signed [VALUE_W-1:0] rv;
            int                        pos;
            bit                        found;
            st    = STS_OK;
            rv    = '0;
            v     = w.value;
            pos   = count;
            found = 1'b0;
            case (w.op)
                OP_INSERT: begin
                    // first stored value that is not smaller
                    for (int i = 0; i < count; i++) begin
                        if (!found && vals[i] >= v) begin
                            pos   = i;
                            found = 1'b1;
                        end
                    end
                    // the duplicate check wins over the full check
                    if (unique_on && pos < count && vals[pos] == v) begin
                        st = STS_DUP;
                    end else if (count >= DEPTH) begin
                        st = STS_FULL;
                    end else begin
                        for (int i = count; i > pos; i--)
                            vals[i] = vals[i-1];
                        vals[pos] = v;
                        count++;
                    end
                end
                OP_READ: begin
                    if (int'(w.index) < count)
                        rv = vals[w.index];
                    else
                        st = STS_BADIDX;
                end
                OP_REMOVE: begin
                    if (int'(w.index) < count) begin
                        for (int i = int'(w.index); i + 1 < count; i++)
                            vals[i] = vals[i+1];
                        count--;
                    end else begin
                        st = STS_BADIDX;
                    end
                end
                default: begin
                end
            endcase
            r.read_value  = rv;
            r.entry_count = CNT_W'(count);
            r.status      = st;
            pending.push_back(r);
        endfunction

        // compare one accepted result with the oldest prediction
        function void check_word(t_out_word got);
            t_out_word want;
            if (pending.size() == 0) begin
                $error("result word with nothing pending: read_value %0d entry_count %0d status %0d",
                       got.read_value, got.entry_count, got.status);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            if (got.read_value !== want.read_value) begin
                $error("read_value expected %0d, actual %0d", want.read_value, got.read_value);
                mismatches++;
            end
            if (got.entry_count !== want.entry_count) begin
                $error("entry_count expected %0d, actual %0d", want.entry_count,
                       got.entry_count);
                mismatches++;
            end
            if (got.status !== want.status) begin
                $error("status expected %0d, actual %0d", want.status, got.status);
                mismatches++;
            end
        endfunction
    endclass

    typedef enum {BURST_FILL, BURST_DRAIN, BURST_MIXED} t_burst;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int          HOLD_CYCLES = 300;
    localparam int unsigned PHASE_WORDS = 340;
    localparam int unsigned PRESS_WORDS = 80;

    logic      i_clk;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_word  i_in_word   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_word o_out_word;
    logic      i_cfg_we    = 1'b0;
    logic      i_cfg_wdata = 1'b0;

    sorted_table_shadow sb;

    // idling knobs, changed per phase by the main sequence
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    // long receiver hold-off: requested by the main sequence, counted by the receiver
    bit          hold_req  = 1'b0;
    bit          hold_done = 1'b0;
    int          hold_left = 0;
    int unsigned cycles    = 0;

    sorted_insert_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("sorted_insert_table test failed");
            $finish;
        end
    end

    // both handshakes are sampled at the edge, ahead of any update it causes
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                sb.note_word(i_in_word);
            if (o_out_valid && !i_out_stall)
                sb.check_word(o_out_word);
        end
    end

    // receiver: random stalls, plus one long hold-off so the block backs up
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            i_out_stall <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            hold_done   <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // present a word and hold it until taken; valid stays high afterwards
    task automatic offer_word(input t_in_word w);
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic issue(input t_op op, input logic signed [VALUE_W-1:0] v,
                         input logic [IDX_W-1:0] idx);
        t_in_word w;
        w.op    = op;
        w.value = v;
        w.index = idx;
        offer_word(w);
    endtask

    // random sender idle cycles between words
    task automatic sender_gap();
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // mode is only changed with nothing in flight
    task automatic set_unique_mode(input bit m);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        // then wait more so that no result is still on its way
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        sb.unique_on = m;
    endtask

    // small values collide often, extremes hit the sign boundary
    function automatic logic signed [VALUE_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 40) begin
            pick_value = $urandom_range(6);
            pick_value = pick_value - 3;
        end else if (r < 55) begin
            case ($urandom_range(5))
                0: pick_value = 32'h8000_0000;
                1: pick_value = 32'h7FFF_FFFF;
                2: pick_value = 32'hFFFF_FFFF;
                3: pick_value = 32'h0000_0000;
                4: pick_value = 32'h8000_0001;
                default: pick_value = 32'h7FFF_FFFE;
            endcase
        end else begin
            pick_value = $urandom;
        end
    endfunction

    // a run of words with a bias: fill toward full, drain toward empty, or mixed
    task automatic run_burst(input t_burst kind, input int unsigned n);
        t_in_word    w;
        int unsigned roll;
        for (int k = 0; k < n; k++) begin
            roll    = $urandom_range(99);
            w.value = pick_value();
            w.index = IDX_W'($urandom_range(15));
            case (kind)
                BURST_FILL: begin
                    w.op = (roll < 85) ? OP_INSERT : OP_READ;
                end
                BURST_DRAIN: begin
                    w.op = (roll < 80) ? OP_REMOVE : OP_READ;
                    // mostly aim at live positions
                    if (sb.count > 0 && $urandom_range(99) < 75)
                        w.index = IDX_W'($urandom_range(sb.count - 1));
                end
                default: begin
                    if (roll < 35)
                        w.op = OP_INSERT;
                    else if (roll < 65)
                        w.op = OP_READ;
                    else if (roll < 95)
                        w.op = OP_REMOVE;
                    else
                        w.op = OP_NONE;
                    if (w.op != OP_INSERT && sb.count > 0 && $urandom_range(99) < 60)
                        w.index = IDX_W'($urandom_range(sb.count - 1));
                end
            endcase
            offer_word(w);
            sender_gap();
        end
    endtask

    task automatic run_phase(input int unsigned words);
        int unsigned sent;
        int unsigned n;
        int unsigned roll;
        t_burst      kind;
        sent = 0;
        while (sent < words) begin
            n    = $urandom_range(8, 24);
            roll = $urandom_range(99);
            if (roll < 35)
                kind = BURST_FILL;
            else if (roll < 65)
                kind = BURST_DRAIN;
            else
                kind = BURST_MIXED;
            run_burst(kind, n);
            sent += n;
        end
    endtask

    initial begin
        int unsigned idle_plan [4] = '{0, 60, 0, 8};
        int unsigned stall_plan[4] = '{0, 0, 60, 8};
        bit          mode_plan [4] = '{1'b1, 1'b0, 1'b1, 1'b0};

        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, unused op, sign extremes, duplicates kept
        issue(OP_READ,   32'sd0, 4'd0);
        issue(OP_REMOVE, 32'sd0, 4'd0);
        issue(OP_NONE,   32'hFFFF_FFFF, 4'd15);
        issue(OP_INSERT, 32'h8000_0000, 4'd15);
        issue(OP_INSERT, 32'h7FFF_FFFF, 4'd0);
        issue(OP_INSERT, 32'sd0, 4'd0);
        issue(OP_INSERT, 32'sd0, 4'd0);
        issue(OP_INSERT, 32'hFFFF_FFFF, 4'd0);
        issue(OP_READ,   32'sd0, 4'd0);
        issue(OP_READ,   32'sd0, 4'd4);
        issue(OP_READ,   32'sd0, 4'd5);
        issue(OP_READ,   32'sd0, 4'd15);
        issue(OP_REMOVE, 32'sd0, 4'd4);
        issue(OP_REMOVE, 32'sd0, 4'd0);

        // unique mode: equal value is dropped, then drain to a single entry and remove it
        set_unique_mode(1'b1);
        issue(OP_INSERT, 32'sd0, 4'd0);
        issue(OP_INSERT, 32'sd5, 4'd0);
        issue(OP_REMOVE, 32'sd0, 4'd3);
        issue(OP_REMOVE, 32'sd0, 4'd0);
        issue(OP_REMOVE, 32'sd0, 4'd0);
        issue(OP_REMOVE, 32'sd0, 4'd0);
        issue(OP_READ,   32'sd0, 4'd0);

        // random phases with their own idling and mode
        for (int p = 0; p < 4; p++) begin
            set_unique_mode(mode_plan[p]);
            send_idle_pct = idle_plan[p];
            stall_pct     = stall_plan[p];
            run_phase(PHASE_WORDS);
        end

        // back-pressure: receiver holds off while the sender keeps offering
        set_unique_mode(1'b1);
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_req      = 1'b1;
        run_phase(PRESS_WORDS);

        // drain everything, then keep waiting so that stray results are caught
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("sorted_insert_table test passed");
        else
            $display("sorted_insert_table test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/sit_pkg.sv
design/sit_cell.sv
design/sorted_insert_table.sv
dv/sorted_insert_table_tb.sv
